// File: hw/rtl/sfc_pkg.sv
package sfc_pkg;

	localparam int EYE_BITS    = 20;
	localparam int COMP_BITS   = 16;
	localparam int PLANE_FRAC  = 14;
	localparam int LIM_BITS    = 19;
	localparam int DIST_BITS   = 21;
	localparam int DBOX_BITS   = 22;
	localparam int PROD_BITS   = COMP_BITS + DBOX_BITS;
	localparam int DOT_BITS    = PROD_BITS + 2;
	localparam int SQ_BITS     = 42;
	localparam int NUM_PLANES  = 6;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 60;
	localparam int PLANE_W     = 3 * COMP_BITS;
	localparam int EYE_W       = 3 * EYE_BITS;

	localparam logic [LIM_BITS-1:0] FAR_LIMIT_RST = 19'd15360;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_PLANE_NEAR   = 3'd0,
		REG_PLANE_FAR    = 3'd1,
		REG_PLANE_LEFT   = 3'd2,
		REG_PLANE_RIGHT  = 3'd3,
		REG_PLANE_TOP    = 3'd4,
		REG_PLANE_BOTTOM = 3'd5,
		REG_EYE_POSITION = 3'd6,
		REG_FAR_LIMIT    = 3'd7
	} sfc_reg_t;

	// Per-item results that ride alongside the square root pipeline.
	typedef struct packed {
		logic                box;
		logic                in_planes;
		logic [LIM_BITS-1:0] limit;
	} sfc_side_t;

endpackage

// File: hw/rtl/sfc_isqrt.sv
module sfc_isqrt
	import sfc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [SQ_BITS-1:0]   in_sq,
	input  sfc_side_t            in_side,
	output logic                 out_valid,
	output logic [DIST_BITS-1:0] out_root,
	output sfc_side_t            out_side
);

	localparam int DIGITS = DIST_BITS;
	localparam int SQW    = SQ_BITS + 1;

	logic [SQW-1:0] n_d    [DIGITS];
	logic [SQW-1:0] r_d    [DIGITS];
	logic [SQW-1:0] n_s    [DIGITS];
	logic [SQW-1:0] r_s    [DIGITS];
	logic           v_s    [DIGITS];
	sfc_side_t      side_s [DIGITS];

	assign n_d[0] = {1'b0, in_sq};
	assign r_d[0] = '0;

	// One result bit per stage, most significant first.
	for (genvar k = 0; k < DIGITS; k++) begin : g_digit
		localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (DIGITS - 1 - k));
		logic [SQW-1:0] trial;
		logic           take;

		if (k > 0) begin : g_link
			assign n_d[k] = n_s[k-1];
			assign r_d[k] = r_s[k-1];
		end

		assign trial = r_d[k] + BIT;
		assign take  = n_d[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= (k == 0) ? in_valid : v_s[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k]    <= take ? n_d[k] - trial : n_d[k];
				r_s[k]    <= take ? (r_d[k] >> 1) + BIT : r_d[k] >> 1;
				side_s[k] <= (k == 0) ? in_side : side_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	assign out_valid = v_s[DIGITS-1];
	assign out_root  = r_s[DIGITS-1][DIST_BITS-1:0];
	assign out_side  = side_s[DIGITS-1];

endmodule

// File: hw/rtl/sphere_frustum_cull_test.sv
// Channel   Dir  Signals                  Contents
// s_axis    in   s_tvalid/s_tready        one sphere per transaction
// m_axis    out  m_tvalid/m_tready        one cull result per transaction
// cfg       in   cfg_we/cfg_index/cfg_data register writes, no read-back
//
// One sphere enters per cycle unless m_axis stalls; each result goes through
// four arithmetic stages, a 21-stage square root and one output register.
// The square root pipeline, one result bit per stage, sets the latency.
// Reset clears all valid bits and loads the register reset values.
// A stall on m_axis freezes the whole pipeline; nothing is lost or repeated.
module sphere_frustum_cull_test
	import sfc_pkg::*;
#(
	parameter int COORD_BITS  = 20,
	parameter int PLANE_COUNT = 6
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                                         s_tvalid,
	output logic                                         s_tready,
	// centre_x, centre_y, centre_z, sphere_radius, limit_distance
	input  logic [((3*COORD_BITS+2*LIM_BITS+7)/8)*8-1:0] s_tdata,
	// req_type
	input  logic                                         s_tuser,

	output logic        m_tvalid,
	input  logic        m_tready,
	// box_pass, visible, eye_distance
	output logic [23:0] m_tdata,

	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int CW_MAX = (COORD_BITS > EYE_BITS) ? COORD_BITS : EYE_BITS;
	localparam int DW     = CW_MAX + 1;
	localparam int RAD_LO = 3 * COORD_BITS;
	localparam int LIM_LO = RAD_LO + LIM_BITS;

	logic [PLANE_W-1:0]  plane_q [NUM_PLANES];
	logic [EYE_W-1:0]    eye_q;
	logic [LIM_BITS-1:0] far_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) plane_q[i] <= '0;
			eye_q <= '0;
			far_q <= FAR_LIMIT_RST;
		end else if (cfg_we) begin
			case (sfc_reg_t'(cfg_index))
				REG_EYE_POSITION: eye_q <= cfg_data[EYE_W-1:0];
				REG_FAR_LIMIT:    far_q <= cfg_data[LIM_BITS-1:0];
				default: plane_q[cfg_index] <= cfg_data[PLANE_W-1:0];
			endcase
		end
	end

	logic en;
	logic out_valid_q;
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	// Stage 1: offsets from the eye, bound and limit.
	logic                  v_s1;
	logic signed [DW-1:0]  d_s1 [3];
	logic [LIM_BITS:0]     bound_s1;
	logic [LIM_BITS-1:0]   limit_s1;
	logic [LIM_BITS-1:0]   radius_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++)
				d_s1[a] <= DW'($signed(s_tdata[a*COORD_BITS +: COORD_BITS]))
					- DW'($signed(eye_q[a*EYE_BITS +: EYE_BITS]));
			radius_s1 <= s_tdata[RAD_LO +: LIM_BITS];
			if (s_tuser) begin
				bound_s1 <= {1'b0, s_tdata[LIM_LO +: LIM_BITS]};
				limit_s1 <= s_tdata[LIM_LO +: LIM_BITS];
			end else begin
				bound_s1 <= {1'b0, far_q} + {1'b0, s_tdata[RAD_LO +: LIM_BITS]};
				limit_s1 <= far_q;
			end
		end
	end

	// Stage 2: per-axis box test. A passing offset fits in DBOX_BITS.
	logic                        v_s2;
	logic                        box_s2;
	logic signed [DBOX_BITS-1:0] d_s2 [3];
	logic [LIM_BITS-1:0]         limit_s2;
	logic [LIM_BITS-1:0]         radius_s2;
	logic [2:0]                  over;

	always_comb begin
		for (int a = 0; a < 3; a++)
			over[a] = (d_s1[a][DW-1] ? DW'(-d_s1[a]) : DW'(d_s1[a]))
				> DW'(bound_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			box_s2 <= over == 3'b000;
			for (int a = 0; a < 3; a++) d_s2[a] <= DBOX_BITS'(d_s1[a]);
			limit_s2  <= limit_s1;
			radius_s2 <= radius_s1;
		end
	end

	// Stage 3: squares and plane products.
	logic                        v_s3;
	logic                        box_s3;
	logic [SQ_BITS-2:0]          sq_s3   [3];
	logic signed [PROD_BITS-1:0] prod_s3 [PLANE_COUNT][3];
	logic [LIM_BITS-1:0]         limit_s3;
	logic [LIM_BITS-1:0]         radius_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				sq_s3[a] <= (SQ_BITS-1)'((2*DBOX_BITS)'(d_s2[a])
					* (2*DBOX_BITS)'(d_s2[a]));
				for (int p = 0; p < PLANE_COUNT; p++)
					prod_s3[p][a] <= PROD_BITS'($signed(plane_q[p][a*COMP_BITS +: COMP_BITS]))
						* PROD_BITS'(d_s2[a]);
			end
			box_s3    <= box_s2;
			limit_s3  <= limit_s2;
			radius_s3 <= radius_s2;
		end
	end

	// Stage 4: squared distance and the plane compares.
	logic                       v_s4;
	logic [SQ_BITS-1:0]         sq_s4;
	sfc_side_t                  side_s4;
	logic [PLANE_COUNT-1:0]     outside;
	logic signed [DOT_BITS-1:0] rad_ext;

	assign rad_ext = DOT_BITS'({1'b0, radius_s3, {PLANE_FRAC{1'b0}}});

	always_comb begin
		for (int p = 0; p < PLANE_COUNT; p++)
			outside[p] = (DOT_BITS'(prod_s3[p][0]) + DOT_BITS'(prod_s3[p][1])
				+ DOT_BITS'(prod_s3[p][2])) > rad_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s4 <= SQ_BITS'(sq_s3[0]) + SQ_BITS'(sq_s3[1]) + SQ_BITS'(sq_s3[2]);
			side_s4.box       <= box_s3;
			side_s4.in_planes <= outside == '0;
			side_s4.limit     <= limit_s3;
		end
	end

	logic                 root_valid;
	logic [DIST_BITS-1:0] root;
	sfc_side_t            root_side;

	sfc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.in_sq    (sq_s4),
		.in_side  (side_s4),
		.out_valid(root_valid),
		.out_root (root),
		.out_side (root_side)
	);

	logic                 box_q;
	logic                 visible_q;
	logic [DIST_BITS-1:0] dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= root_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			box_q     <= root_side.box;
			visible_q <= root_side.box && root_side.in_planes
				&& (root < DIST_BITS'(root_side.limit));
			dist_q    <= root_side.box ? root : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, dist_q, visible_q, box_q};

	a_box_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !box_q |-> !visible_q && dist_q == '0)
		else $error("failed box test must give zero distance and no visibility");

	a_visible_near: assert property (@(posedge clk) disable iff (!arst_n)
		en && root_valid && root_side.box && root >= DIST_BITS'(root_side.limit)
		|=> !visible_q)
		else $error("sphere at or beyond the limit marked visible");

	a_enter_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted transaction did not enter the first stage");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s4) && $stable(v_s1))
		else $error("pipeline moved during a stall");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import sfc_pkg::*;

	localparam int CB = 20;
	localparam int TDATA_W = ((3*CB+2*LIM_BITS+7)/8)*8;
	localparam int LONG_HOLD = 400;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		bit                   carried;
		logic [CB-1:0]        cx, cy, cz;
		logic [LIM_BITS-1:0]  radius;
		logic [LIM_BITS-1:0]  lim;
	} sphere_t;

	typedef struct {
		bit                   box;
		bit                   vis;
		logic [DIST_BITS-1:0] eye_dist;
	} verdict_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [TDATA_W-1:0] s_tdata = '0;
	logic s_tuser = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [23:0] m_tdata;
	logic cfg_we = 0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	// Shadow copy of the block's registers.
	logic [PLANE_W-1:0]  planes [NUM_PLANES];
	logic [EYE_W-1:0]    eye;
	logic [LIM_BITS-1:0] far_lim;

	sphere_t  sphere_q[$];
	verdict_t verdict_q[$];
	bit failed = 0;
	bit hold_req = 0;
	bit hold_done = 0;
	int tx_gap = 0;
	int rx_gap = 0;
	int idle_cnt = 0;

	sphere_frustum_cull_test DUT (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned n);
		longint unsigned root, t;
		root = 0;
		for (int b = 21; b >= 0; b--) begin
			t = root | (64'd1 << b);
			if (t * t <= n)
				root = t;
		end
		return root;
	endfunction

	function automatic verdict_t cull_predict(sphere_t s);
		verdict_t v;
		longint d [3];
		longint bound, limit, dot;
		longint unsigned sq;
		logic [CB-1:0] c [3];
		bit all_in;
		v = '{box: 0, vis: 0, eye_dist: '0};
		c[0] = s.cx;
		c[1] = s.cy;
		c[2] = s.cz;
		for (int a = 0; a < 3; a++)
			d[a] = longint'($signed(c[a])) - longint'($signed(eye[a*EYE_BITS +: EYE_BITS]));
		if (s.carried) begin
			bound = longint'(s.lim);
			limit = longint'(s.lim);
		end else begin
			bound = longint'(far_lim) + longint'(s.radius);
			limit = longint'(far_lim);
		end
		for (int a = 0; a < 3; a++)
			if ((d[a] < 0 ? -d[a] : d[a]) > bound)
				return v;
		sq = 0;
		for (int a = 0; a < 3; a++)
			sq += d[a] * d[a];
		v.eye_dist = DIST_BITS'(floor_sqrt(sq));
		all_in = 1;
		for (int p = 0; p < NUM_PLANES; p++) begin
			dot = 0;
			for (int a = 0; a < 3; a++)
				dot += longint'($signed(planes[p][a*COMP_BITS +: COMP_BITS])) * d[a];
			if (dot > (longint'(s.radius) <<< PLANE_FRAC))
				all_in = 0;
		end
		v.box = 1;
		v.vis = all_in && (longint'(v.eye_dist) < limit);
		return v;
	endfunction

	// Sender: a new sphere is put on the bus only when the previous one was taken.
	always @(posedge clk) begin
		sphere_t s;
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				s_tvalid <= 0;
			end else if (sphere_q.size() > 0) begin
				s = sphere_q.pop_front();
				verdict_q.push_back(cull_predict(s));
				s_tdata <= {6'd0, s.lim, s.radius, s.cz, s.cy, s.cx};
				s_tuser <= s.carried;
				s_tvalid <= 1;
				tx_gap = pick_gap();
			end else begin
				s_tvalid <= 0;
			end
		end
	end

	// Receiver with random back-pressure and one long hold-off on request.
	always @(posedge clk) begin
		verdict_t e;
		if (m_tvalid && m_tready) begin
			if (verdict_q.size() == 0) begin
				$error("result with no sphere outstanding: %h", m_tdata);
				failed = 1;
			end else begin
				e = verdict_q.pop_front();
				if (m_tdata[0] !== e.box) begin
					$error("box_pass exp %0d got %0d", e.box, m_tdata[0]);
					failed = 1;
				end
				if (m_tdata[1] !== e.vis) begin
					$error("visible exp %0d got %0d", e.vis, m_tdata[1]);
					failed = 1;
				end
				if (m_tdata[22:2] !== e.eye_dist) begin
					$error("eye_distance exp %0d got %0d", e.eye_dist, m_tdata[22:2]);
					failed = 1;
				end
			end
		end
		if (rx_gap > 0) begin
			rx_gap--;
			m_tready <= 0;
		end else if (hold_req && !hold_done) begin
			rx_gap = LONG_HOLD;
			hold_done = 1;
			m_tready <= 0;
		end else begin
			m_tready <= 1;
			rx_gap = pick_gap();
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || verdict_q.size() == 0)
			idle_cnt = 0;
		else
			idle_cnt++;
		if (idle_cnt >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_reg(sfc_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == REG_EYE_POSITION)
			eye = val[EYE_W-1:0];
		else if (idx == REG_FAR_LIMIT)
			far_lim = val[LIM_BITS-1:0];
		else
			planes[idx] = val[PLANE_W-1:0];
	endtask

	task automatic drain();
		while (sphere_q.size() > 0 || verdict_q.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CB-1:0] near_coord(logic [EYE_BITS-1:0] base, int spread);
		int off;
		off = $urandom_range(0, 2 * spread) - spread;
		return CB'(int'(base) + off);
	endfunction

	// Mostly spheres around the eye so the plane and distance logic is exercised,
	// the rest unconstrained over the full field ranges.
	task automatic queue_random(int n, int spread);
		sphere_t s;
		for (int i = 0; i < n; i++) begin
			s.carried = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 4) == 0) begin
				s.cx = CB'($urandom);
				s.cy = CB'($urandom);
				s.cz = CB'($urandom);
				s.radius = LIM_BITS'($urandom);
				s.lim = LIM_BITS'($urandom);
			end else begin
				s.cx = near_coord(eye[19:0], spread);
				s.cy = near_coord(eye[39:20], spread);
				s.cz = near_coord(eye[59:40], spread);
				s.radius = ($urandom_range(0, 3) == 0) ? LIM_BITS'($urandom)
					: LIM_BITS'($urandom_range(0, spread));
				s.lim = ($urandom_range(0, 3) == 0) ? LIM_BITS'($urandom)
					: LIM_BITS'($urandom_range(0, 2 * spread));
			end
			sphere_q.push_back(s);
		end
	endtask

	function automatic logic [PLANE_W-1:0] rand_plane();
		return {16'($urandom), 16'($urandom), 16'($urandom)};
	endfunction

	function automatic logic [EYE_W-1:0] rand_eye(int spread);
		return {20'($urandom_range(0, 2*spread) - spread),
			20'($urandom_range(0, 2*spread) - spread),
			20'($urandom_range(0, 2*spread) - spread)};
	endfunction

	task automatic add(bit carried, int x, int y, int z, int r, int l);
		sphere_q.push_back('{carried, CB'(x), CB'(y), CB'(z), LIM_BITS'(r), LIM_BITS'(l)});
	endtask

	initial begin
		for (int p = 0; p < NUM_PLANES; p++)
			planes[p] = '0;
		eye = '0;
		far_lim = FAR_LIMIT_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1;

		// Reset values: no plane rejects, distance against 60.0.
		add(0, 0, 0, 0, 0, 0);
		add(0, 15360, 0, 0, 0, 0);
		add(0, 15359, 0, 0, 0, 0);
		add(0, 15361, 0, 0, 0, 0);
		add(0, 15361, 0, 0, 1, 0);
		add(1, -524288, 0, 0, 0, 524287);
		add(1, 524287, 524287, 524287, 524287, 524287);
		add(0, -524288, -524288, -524288, 524287, 0);
		add(0, 524287, -524288, 524287, 524287, 524287);
		add(1, 256, 0, 0, 0, 256);
		add(1, 255, 0, 0, 0, 256);
		add(1, 257, 0, 0, 0, 256);
		add(1, 0, 0, -100, 7, 0);
		drain();

		// Near plane along +x: a dot product equal to the radius is still inside.
		write_reg(REG_PLANE_NEAR, CFG_DATA_BITS'(48'h0000_0000_4000));
		write_reg(REG_PLANE_FAR, CFG_DATA_BITS'(48'h0000_0000_C000));
		add(1, 1000, 0, 0, 1000, 5000);
		add(1, 1001, 0, 0, 1000, 5000);
		add(1, -1001, 0, 0, 1000, 5000);
		add(1, -1000, 0, 0, 1000, 5000);
		add(0, 0, 3000, 4000, 0, 0);
		add(0, 524287, 524287, 524287, 524287, 0);
		drain();

		for (int p = 0; p < NUM_PLANES; p++)
			write_reg(sfc_reg_t'(p), CFG_DATA_BITS'(rand_plane()));
		write_reg(REG_EYE_POSITION, rand_eye(20000));
		write_reg(REG_FAR_LIMIT, CFG_DATA_BITS'($urandom_range(1000, 30000)));
		queue_random(200, 20000);
		drain();

		// Extremes, with a long receiver hold-off so the pipeline backs up.
		for (int p = 0; p < NUM_PLANES; p++)
			write_reg(sfc_reg_t'(p), CFG_DATA_BITS'((p % 2) ? 48'hFFFF_FFFF_FFFF
				: 48'h8000_8000_8000));
		write_reg(REG_EYE_POSITION, {20'h7FFFF, 20'h80000, 20'h7FFFF});
		write_reg(REG_FAR_LIMIT, CFG_DATA_BITS'(19'h7FFFF));
		queue_random(150, 300000);
		@(posedge clk);
		hold_req <= 1;
		drain();

		for (int p = 0; p < NUM_PLANES; p++)
			write_reg(sfc_reg_t'(p), CFG_DATA_BITS'(rand_plane()));
		write_reg(REG_EYE_POSITION, '0);
		write_reg(REG_FAR_LIMIT, '0);
		queue_random(150, 3000);
		drain();

		for (int p = 0; p < NUM_PLANES; p++)
			write_reg(sfc_reg_t'(p), (p < 3) ? CFG_DATA_BITS'(rand_plane()) : '0);
		write_reg(REG_EYE_POSITION, CFG_DATA_BITS'({$urandom, $urandom}));
		write_reg(REG_FAR_LIMIT, CFG_DATA_BITS'($urandom));
		queue_random(150, 100000);
		drain();

		if (!failed)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: sphere_frustum_cull_test.f
hw/rtl/sfc_pkg.sv
hw/rtl/sfc_isqrt.sv
hw/rtl/sphere_frustum_cull_test.sv
dv/tb.sv
